// ----- rtl/core/aes_pkg.sv -----
// aes_pkg: shared constants, sbox tables and gf helpers for the aes-128 core
// used by aes_round and aes128_block_cipher_top; no dependencies
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NUM_ROUNDS    = 10;
  localparam int unsigned NUM_KEY_WORDS = 44;
  localparam int unsigned NUM_CFG_REGS  = 4;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [1:0] CFG_KEY_WORD_0 = 2'd0;
  localparam logic [1:0] CFG_KEY_WORD_1 = 2'd1;
  localparam logic [1:0] CFG_KEY_WORD_2 = 2'd2;
  localparam logic [1:0] CFG_KEY_WORD_3 = 2'd3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic decrypt;
    logic first;
    logic last;
  } round_ctl_t;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xtime(p);
    end
    gf_mul = acc;
  endfunction

  function automatic byte_t gf_inv(input byte_t a);
    byte_t r;
    byte_t p;
    r = 8'h01;
    p = a;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    gf_inv = r;
  endfunction

  function automatic byte_t rotl8(input byte_t x, input int unsigned n);
    rotl8 = byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic byte_t sbox_calc(input byte_t x);
    byte_t b;
    b = gf_inv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t rsbox_calc(input byte_t s);
    rsbox_calc = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  typedef byte_t sbox_tab_t [256];

  function automatic sbox_tab_t make_sbox(input logic inverse);
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? rsbox_calc(byte_t'(i)) : sbox_calc(byte_t'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_tab_t SBOX  = make_sbox(1'b0);
  localparam sbox_tab_t RSBOX = make_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- rtl/core/aes_round.sv -----
// aes_round: one shared encrypt/decrypt round applied to the 128-bit state
// depends on aes_pkg for sbox tables and gf helpers
`timescale 1ns / 1ps
module aes_round (
  input  aes_pkg::round_ctl_t ctl,
  input  logic [127:0]        state_in,
  input  logic [127:0]        round_key,
  output logic [127:0]        state_out
);

  aes_pkg::byte_t s  [16];
  aes_pkg::byte_t sh [16];
  aes_pkg::byte_t sb [16];
  aes_pkg::byte_t mx [16];
  aes_pkg::byte_t ak [16];
  aes_pkg::byte_t res[16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.decrypt) begin
          sh[4*c + r] = s[4*((c - r + 4) % 4) + r];
        end else begin
          sh[4*c + r] = s[4*((c + r) % 4) + r];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl.decrypt) begin
        sb[i] = aes_pkg::RSBOX[sh[i]];
      end else begin
        sb[i] = aes_pkg::SBOX[sh[i]];
      end
    end
    // encrypt: shift, sub, mix, add; decrypt: shift, sub, add, mix
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.decrypt) begin
          ak[4*c + r] = sb[4*c + r] ^ round_key[127 - 8*(4*c + r) -: 8];
          mx[4*c + r] = 8'h00;
        end else begin
          mx[4*c + r] = aes_pkg::gf_mul(8'h02, sb[4*c + r])
                      ^ aes_pkg::gf_mul(8'h03, sb[4*c + (r + 1) % 4])
                      ^ sb[4*c + (r + 2) % 4] ^ sb[4*c + (r + 3) % 4];
          ak[4*c + r] = 8'h00;
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.first) begin
          res[4*c + r] = s[4*c + r] ^ round_key[127 - 8*(4*c + r) -: 8];
        end else if (ctl.decrypt) begin
          if (ctl.last) begin
            res[4*c + r] = ak[4*c + r];
          end else begin
            res[4*c + r] = aes_pkg::gf_mul(8'h0E, ak[4*c + r])
                         ^ aes_pkg::gf_mul(8'h0B, ak[4*c + (r + 1) % 4])
                         ^ aes_pkg::gf_mul(8'h0D, ak[4*c + (r + 2) % 4])
                         ^ aes_pkg::gf_mul(8'h09, ak[4*c + (r + 3) % 4]);
          end
        end else if (ctl.last) begin
          res[4*c + r] = sb[4*c + r] ^ round_key[127 - 8*(4*c + r) -: 8];
        end else begin
          res[4*c + r] = mx[4*c + r] ^ round_key[127 - 8*(4*c + r) -: 8];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127 - 8*i -: 8] = res[i];
    end
  end

endmodule

// ----- rtl/core/aes128_block_cipher_top.sv -----
// aes-128 ecb cipher top: key expansion sequencer, round-key memory, shared round
// depends on aes_pkg and aes_round
// usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write key words 0..3 while idle and
//   no input beat waits; indexes above three are dropped. any key write marks
//   the schedule stale.
//   in_valid/in_stall carry one beat: action (0 encrypt, 1 decrypt) and
//   block_hi/block_lo. in_stall is high while a beat is being worked on.
//   out_valid/out_stall return result_hi/result_lo, one beat per input.
// sequencing:
//   per round the sequencer issues the first round-key address, reads the four
//   round-key words one by one from the registered-read schedule memory, then
//   passes the state once through the shared round unit; eleven rounds in all.
//   no new beat is taken until the result has been taken from the output.
//   after reset or a key write, the first beat first runs the expansion,
//   one word per cycle.
// reset: control clears, the key words return to zero, the schedule is stale.
// a stalled result holds on the output ports until taken.
`timescale 1ns / 1ps
module aes128_block_cipher_top #(
  parameter int unsigned NumKeyWords = aes_pkg::NUM_KEY_WORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [63:0]                   in_block_hi,
  input  logic [63:0]                   in_block_lo,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   out_result_hi,
  output logic [63:0]                   out_result_lo
);

  localparam int unsigned KwW = $clog2(NumKeyWords);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       key_r [aes_pkg::NUM_CFG_REGS];
  logic              expanded_r;
  logic [31:0]       rk_mem [NumKeyWords];
  logic [KwW-1:0]    widx_r;
  logic [31:0]       w1_r, w2_r, w3_r, w4_r;
  logic [7:0]        rcon_r;
  logic [KwW-1:0]    ridx_r;
  logic [31:0]       rdata_r;
  logic [1:0]        col_r;
  logic [95:0]       kacc_r;
  logic [3:0]        round_r;
  logic              dec_r;
  logic [127:0]      st_r;
  logic [127:0]      rnd_out;
  logic              mem_we;
  logic [31:0]       mem_wd;
  logic [31:0]       new_w;
  logic              rd_pend_r;
  aes_pkg::round_ctl_t ctl;

  assign cfg_ready     = (state_r == ST_IDLE) && !in_valid;
  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_result_hi = st_r[127:64];
  assign out_result_lo = st_r[63:0];

  // next expanded word from the last four
  always_comb begin
    if (widx_r[1:0] == 2'd0) begin
      new_w = w1_r ^ aes_pkg::sub_word({w4_r[23:0], w4_r[31:24]}) ^ {rcon_r, 24'h0};
    end else begin
      new_w = w1_r ^ w4_r;
    end
    mem_we = (state_r == ST_EXPAND);
    mem_wd = (widx_r < KwW'(4)) ? key_r[widx_r[1:0]] : new_w;
  end

  always_ff @(posedge clk) begin
    if (mem_we) rk_mem[widx_r] <= mem_wd;
    rdata_r <= rk_mem[ridx_r];
  end

  assign ctl.decrypt = dec_r;
  assign ctl.first   = (round_r == 4'd0);
  assign ctl.last    = (round_r == 4'(aes_pkg::NUM_ROUNDS));

  aes_round u_round (
    .ctl       (ctl),
    .state_in  (st_r),
    .round_key ({kacc_r, rdata_r}),
    .state_out (rnd_out)
  );

  // key word index for round r column c
  function automatic logic [KwW-1:0] rk_index(input logic [3:0] r, input logic dec,
                                             input logic [1:0] c);
    logic [3:0] kr;
    kr = dec ? 4'(aes_pkg::NUM_ROUNDS) - r : r;
    rk_index = KwW'({kr, c});
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = expanded_r ? ST_FETCH : ST_EXPAND;
      ST_EXPAND: if (widx_r == KwW'(NumKeyWords - 1)) state_nxt = ST_FETCH;
      ST_FETCH:  if (col_r == 2'd3 && rd_pend_r) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = (round_r == 4'(aes_pkg::NUM_ROUNDS)) ? ST_OUT : ST_FETCH;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      expanded_r <= 1'b0;
      for (int i = 0; i < int'(aes_pkg::NUM_CFG_REGS); i++) key_r[i] <= 32'h0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready && !cfg_index[aes_pkg::CFG_IDX_W]) begin
        key_r[cfg_index[aes_pkg::CFG_IDX_W-1:0]] <= cfg_data;
        expanded_r <= 1'b0;
      end
      if (state_r == ST_EXPAND && state_nxt == ST_FETCH) expanded_r <= 1'b1;
    end
  end

  // datapath and sequencing counters
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        widx_r    <= '0;
        rcon_r    <= 8'h01;
        col_r     <= 2'd0;
        round_r   <= 4'd0;
        rd_pend_r <= 1'b0;
        dec_r     <= in_action;
        st_r      <= {in_block_hi, in_block_lo};
        ridx_r    <= rk_index(4'd0, in_action, 2'd0);
      end
      ST_EXPAND: begin
        widx_r <= widx_r + KwW'(1);
        w1_r   <= w2_r;
        w2_r   <= w3_r;
        w3_r   <= w4_r;
        w4_r   <= mem_wd;
        if (widx_r >= KwW'(4) && widx_r[1:0] == 2'd0) rcon_r <= aes_pkg::xtime(rcon_r);
      end
      ST_FETCH: begin
        // address issued last cycle; data arrives registered
        if (!rd_pend_r) begin
          rd_pend_r <= 1'b1;
          ridx_r    <= rk_index(round_r, dec_r, 2'd1);
        end else if (col_r != 2'd3) begin
          kacc_r <= {kacc_r[63:0], rdata_r};
          col_r  <= col_r + 2'd1;
          // last column address holds so its word stays in rdata_r for the round
          if (col_r != 2'd2) ridx_r <= rk_index(round_r, dec_r, col_r + 2'd2);
        end
      end
      ST_ROUND: begin
        st_r      <= rnd_out;
        round_r   <= round_r + 4'd1;
        col_r     <= 2'd0;
        rd_pend_r <= 1'b0;
        ridx_r    <= rk_index(round_r + 4'd1, dec_r, 2'd0);
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_hi) && $stable(out_result_lo))
    else $error("result changed while stalled");
  a_busy_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cfg_ready)
    else $error("config open while busy");
  a_fresh_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> expanded_r)
    else $error("round ran on stale schedule");
`endif

endmodule

// ----- bench/aes128_block_cipher_top_tb.sv -----
// aes128_block_cipher_top_tb: self-checking bench for the aes-128 ecb core, with a
// queue-fed driver, a clocked monitor and a behavioral cipher predictor
// depends on aes_pkg and aes128_block_cipher_top
`timescale 1ns / 1ps
module aes128_block_cipher_top_tb;

  localparam logic [aes_pkg::CFG_IDX_W:0] SPARE_IDX_LO = 3'd4;
  localparam logic [aes_pkg::CFG_IDX_W:0] SPARE_IDX_HI = 3'd7;
  localparam logic [aes_pkg::CFG_IDX_W:0] KEY_IDX [4] = '{
    {1'b0, aes_pkg::CFG_KEY_WORD_0}, {1'b0, aes_pkg::CFG_KEY_WORD_1},
    {1'b0, aes_pkg::CFG_KEY_WORD_2}, {1'b0, aes_pkg::CFG_KEY_WORD_3}
  };
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_BEATS   = 200;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic        action;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [aes_pkg::CFG_IDX_W:0]   cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_action = 1'b0;
  logic [63:0]                   in_block_hi = '0;
  logic [63:0]                   in_block_lo = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [63:0]                   out_result_hi;
  logic [63:0]                   out_result_lo;

  block_beat_t pending_blocks[$];
  cipher_out_t expected_blocks[$];
  logic        beat_taken = 1'b0;
  int          send_idle_pct = 38;
  int          recv_idle_pct = 86;
  int          errors = 0;
  int          blocks_in = 0;
  int          blocks_out = 0;
  int          key_writes = 0;
  int          decrypts = 0;

  // predictor state
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];
  logic [31:0] key_regs [4] = '{default: '0};
  logic [31:0] sched [44];
  logic        sched_fresh = 1'b0;
  logic [7:0]  st [16];

  aes128_block_cipher_top uut (.*);

  always #4 clk = ~clk;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rol(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic void build_sbox();
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (fmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      fwd_sbox[x] = inv ^ rol(inv, 1) ^ rol(inv, 2) ^ rol(inv, 3) ^ rol(inv, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) rev_sbox[fwd_sbox[x]] = 8'(x);
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    for (int i = 0; i < 4; i++) sched[i] = key_regs[i];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
        t ^= {rcon, 24'h0};
        rcon = dbl(rcon);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_fresh = 1'b1;
  endfunction

  function automatic void add_key(input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = sched[rnd*4 + c];
      for (int r = 0; r < 4; r++) st[4*c + r] ^= w[31 - 8*r -: 8];
    end
  endfunction

  function automatic void shift_state(input logic inverse);
    logic [7:0] t [16];
    int src;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inverse ? (c - r + 4) % 4 : (c + r) % 4;
        t[4*c + r] = st[4*src + r];
      end
    st = t;
  endfunction

  function automatic void sub_state(input logic inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? rev_sbox[st[i]] : fwd_sbox[st[i]];
  endfunction

  function automatic void mix_state(input logic inverse);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = st[4*c + r];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= fmul(coef[(k - r + 4) % 4], col[k]);
        st[4*c + r] = v;
      end
    end
  endfunction

  function automatic cipher_out_t cipher_block(input block_beat_t b);
    cipher_out_t res;
    if (!sched_fresh) expand_schedule();
    for (int i = 0; i < 8; i++) begin
      st[i]     = b.hi[63 - 8*i -: 8];
      st[8 + i] = b.lo[63 - 8*i -: 8];
    end
    if (!b.action) begin
      add_key(0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
        sub_state(1'b0);
        shift_state(1'b0);
        if (rnd != 10) mix_state(1'b0);
        add_key(rnd);
      end
    end else begin
      add_key(10);
      for (int rnd = 9; rnd >= 0; rnd--) begin
        shift_state(1'b1);
        sub_state(1'b1);
        add_key(rnd);
        if (rnd != 0) mix_state(1'b1);
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8*i -: 8] = st[i];
      res.lo[63 - 8*i -: 8] = st[8 + i];
    end
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!in_valid || beat_taken) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          in_action   <= pending_blocks[0].action;
          in_block_hi <= pending_blocks[0].hi;
          in_block_lo <= pending_blocks[0].lo;
          void'(pending_blocks.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and predictor update
  always @(posedge clk) begin
    cipher_out_t exp_blk;
    block_beat_t got;
    beat_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        key_writes++;
        if (!cfg_index[aes_pkg::CFG_IDX_W]) begin
          key_regs[cfg_index[aes_pkg::CFG_IDX_W-1:0]] = cfg_data;
          sched_fresh = 1'b0;
        end
      end
      if (in_valid && !in_stall) begin
        got = '{in_action, in_block_hi, in_block_lo};
        expected_blocks.push_back(cipher_block(got));
        blocks_in++;
        if (in_action) decrypts++;
      end
      if (out_valid && !out_stall) begin
        blocks_out++;
        if (expected_blocks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat hi=%h lo=%h", $time, out_result_hi,
                   out_result_lo);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_result_hi !== exp_blk.hi) begin
            errors++;
            $display("%0t: result_hi mismatch expected %h actual %h", $time, exp_blk.hi,
                     out_result_hi);
          end
          if (out_result_lo !== exp_blk.lo) begin
            errors++;
            $display("%0t: result_lo mismatch expected %h actual %h", $time, exp_blk.lo,
                     out_result_lo);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [aes_pkg::CFG_IDX_W:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [127:0] k);
    for (int i = 0; i < 4; i++) write_reg(KEY_IDX[i], k[127 - 32*i -: 32]);
  endtask

  task automatic queue_block(input logic act, input logic [127:0] blk);
    pending_blocks.push_back('{act, blk[127:64], blk[63:0]});
  endtask

  initial begin
    logic [127:0] k;
    build_sbox();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset key of all zeros, no write yet
    queue_block(1'b0, '0);
    queue_block(1'b1, '1);
    drain();
    // spare indexes are dropped
    write_reg(SPARE_IDX_LO, 32'hDEADBEEF);
    write_reg(SPARE_IDX_HI, 32'hFFFFFFFF);
    queue_block(1'b0, '0);
    drain();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    queue_block(1'b0, 128'h00112233445566778899aabbccddeeff);
    queue_block(1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    queue_block(1'b0, '1);
    queue_block(1'b1, '0);
    queue_block(1'b0, {8{16'hAA55}});
    queue_block(1'b1, {8{16'h55AA}});
    drain();
    // one key word changed after use forces a new expansion
    write_reg(KEY_IDX[2], 32'h80000001);
    queue_block(1'b0, 128'h00112233445566778899aabbccddeeff);
    queue_block(1'b1, 128'h00112233445566778899aabbccddeeff);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 38 : (ph < 6) ? 86 : 0;
      recv_idle_pct = (ph < 3) ? 86 : (ph < 6) ? 38 : 0;
      k = {$urandom, $urandom, $urandom, $urandom};
      if (ph == 0) k = '0;
      if (ph == 1) k = '1;
      load_key(k);
      for (int i = 0; i < PHASE_BEATS; i++)
        queue_block(1'(($urandom)), {$urandom, $urandom, $urandom, $urandom});
      drain();
    end

    $display("covered %0d blocks (%0d decrypt), %0d results, %0d register writes",
             blocks_in, decrypts, blocks_out, key_writes);
    $display("random keys plus zero, all-ones and standard vectors under three idle mixes");
    if (errors == 0)
      $display("** aes128_block_cipher_top: PASSED **");
    else
      $display("** aes128_block_cipher_top: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("** aes128_block_cipher_top: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_cipher_top.sv
bench/aes128_block_cipher_top_tb.sv
